>>> rtl/cmc_pkg.sv
package cmc_pkg;

  localparam int MAX_MAP_LEN  = 1048576;
  localparam int SET_SIZE     = 4;
  localparam int PACKED_CODES = 4;
  localparam int CODE_W       = 8;
  localparam int CNT_W        = $clog2(MAX_MAP_LEN + 1);
  localparam int POS_W        = $clog2(MAX_MAP_LEN);
  localparam int SET_CNT_W    = 3;
  localparam int USED_MAX     = (SET_SIZE < PACKED_CODES) ? SET_SIZE : PACKED_CODES;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = PACKED_CODES * CODE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEC_CODES  = 3'd0,
    CFG_DEC_COUNT  = 3'd1,
    CFG_EMPTY      = 3'd2,
    CFG_HEAD       = 3'd3,
    CFG_GOOD_HEAD  = 3'd4,
    CFG_GOOD_BODY  = 3'd5
  } cmc_cfg_idx_t;

  typedef struct packed {
    logic [CODE_W-1:0] status_code;
    logic              last;
  } cmc_in_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             is_head;
    logic             is_good_head;
    logic [CNT_W-1:0] decodable_total;
    logic [CNT_W-1:0] head_total;
    logic [CNT_W-1:0] run_starts;
    logic [CNT_W-1:0] empty_total;
    logic [CNT_W-1:0] good_head_total;
    logic [CNT_W-1:0] good_body_total;
    logic             map_done;
  } cmc_out_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] dec_codes;
    logic [SET_CNT_W-1:0]  dec_count;
    logic [CODE_W-1:0]     empty_code;
    logic [CODE_W-1:0]     head_code;
    logic [CODE_W-1:0]     good_head_code;
    logic [CODE_W-1:0]     good_body_code;
  } cmc_cfg_t;

  typedef struct packed {
    logic decodable;
    logic head;
    logic empty;
    logic good_head;
    logic good_body;
  } cmc_class_t;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] lim;
    lim = CNT_W'(MAX_MAP_LEN);
    return (c < lim) ? c + 1'b1 : lim;
  endfunction

endpackage

>>> rtl/cmc_classify.sv
module cmc_classify (
  input  cmc_pkg::cmc_cfg_t                cfg,
  input  logic [cmc_pkg::CODE_W-1:0]       code,
  output cmc_pkg::cmc_class_t              cls
);

  logic [cmc_pkg::SET_CNT_W-1:0] used;
  logic [cmc_pkg::PACKED_CODES-1:0] hit;
  logic in_set;

  always_comb begin
    if (cfg.dec_count > cmc_pkg::SET_CNT_W'(cmc_pkg::USED_MAX)) begin
      used = cmc_pkg::SET_CNT_W'(cmc_pkg::USED_MAX);
    end else begin
      used = cfg.dec_count;
    end
  end

  // one comparator per packed slot, gated by the number of slots in use
  always_comb begin
    for (int i = 0; i < cmc_pkg::PACKED_CODES; i++) begin
      hit[i] = (cmc_pkg::SET_CNT_W'(i) < used) &&
               (cfg.dec_codes[i*cmc_pkg::CODE_W +: cmc_pkg::CODE_W] == code);
    end
  end

  assign in_set = |hit;

  always_comb begin
    cls.decodable = in_set;
    cls.head      = in_set && (code == cfg.head_code);
    cls.empty     = !in_set && (code == cfg.empty_code);
    cls.good_head = !in_set && (code != cfg.empty_code) && (code == cfg.good_head_code);
    cls.good_body = !in_set && (code != cfg.empty_code) && (code != cfg.good_head_code) &&
                    (code == cfg.good_body_code);
  end

endmodule

>>> rtl/cmc_stats.sv
module cmc_stats (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  cmc_pkg::cmc_class_t  cls,
  input  logic                 last,
  output cmc_pkg::cmc_out_t    res_r
);

  logic [cmc_pkg::CNT_W-1:0] pos_r, dec_r, head_r, run_r, empty_r, ghead_r, gbody_r;
  logic [cmc_pkg::CNT_W-1:0] pos_nxt, dec_nxt, head_nxt, run_nxt, empty_nxt, ghead_nxt,
                             gbody_nxt;
  logic                      prev_dec_r, prev_dec_nxt;
  logic [cmc_pkg::CNT_W-1:0] pos_cap;
  cmc_pkg::cmc_out_t         res_nxt;

  localparam logic [cmc_pkg::CNT_W-1:0] PosTop = cmc_pkg::CNT_W'(cmc_pkg::MAX_MAP_LEN - 1);

  always_comb begin
    pos_cap   = (pos_r > PosTop) ? PosTop : pos_r;
    pos_nxt   = cmc_pkg::bump(pos_r);
    dec_nxt   = cls.decodable ? cmc_pkg::bump(dec_r) : dec_r;
    head_nxt  = cls.head ? cmc_pkg::bump(head_r) : head_r;
    run_nxt   = (cls.decodable && !prev_dec_r) ? cmc_pkg::bump(run_r) : run_r;
    empty_nxt = cls.empty ? cmc_pkg::bump(empty_r) : empty_r;
    ghead_nxt = cls.good_head ? cmc_pkg::bump(ghead_r) : ghead_r;
    gbody_nxt = cls.good_body ? cmc_pkg::bump(gbody_r) : gbody_r;
    prev_dec_nxt = cls.decodable;

    res_nxt.position        = pos_cap[cmc_pkg::POS_W-1:0];
    res_nxt.is_head         = cls.head;
    res_nxt.is_good_head    = cls.good_head;
    res_nxt.decodable_total = dec_nxt;
    res_nxt.head_total      = head_nxt;
    res_nxt.run_starts      = run_nxt;
    res_nxt.empty_total     = empty_nxt;
    res_nxt.good_head_total = ghead_nxt;
    res_nxt.good_body_total = gbody_nxt;
    res_nxt.map_done        = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      dec_r      <= '0;
      head_r     <= '0;
      run_r      <= '0;
      empty_r    <= '0;
      ghead_r    <= '0;
      gbody_r    <= '0;
      prev_dec_r <= 1'b0;
    end else if (step) begin
      if (last) begin
        // map closed: start the next one from scratch
        pos_r      <= '0;
        dec_r      <= '0;
        head_r     <= '0;
        run_r      <= '0;
        empty_r    <= '0;
        ghead_r    <= '0;
        gbody_r    <= '0;
        prev_dec_r <= 1'b0;
      end else begin
        pos_r      <= pos_nxt;
        dec_r      <= dec_nxt;
        head_r     <= head_nxt;
        run_r      <= run_nxt;
        empty_r    <= empty_nxt;
        ghead_r    <= ghead_nxt;
        gbody_r    <= gbody_nxt;
        prev_dec_r <= prev_dec_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

endmodule

>>> rtl/cluster_map_classifier.sv
// Path: an accepted beat is held in the input register, then classified and counted into the
// result register, from which it is offered on the result channel.
// Throughput: one beat per cycle while results are taken; both stages advance whenever the result register is free.
// Reset (rst_n low, synchronous): config registers, all map counters and both valid flags
// clear; a beat with last set also clears the map counters after its result is built.
module cluster_map_classifier (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cmc_pkg::cmc_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cmc_pkg::cmc_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  cmc_pkg::cmc_cfg_t   cfg_r;
  cmc_pkg::cmc_in_t    s1_data_r;
  cmc_pkg::cmc_class_t cls;
  logic                s1_valid_r;
  logic                out_valid_r;
  logic                s2_ready;
  logic                step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cmc_pkg::cmc_cfg_idx_t'(cfg_index))
        cmc_pkg::CFG_DEC_CODES: cfg_r.dec_codes      <= cfg_data;
        cmc_pkg::CFG_DEC_COUNT: cfg_r.dec_count      <= cfg_data[cmc_pkg::SET_CNT_W-1:0];
        cmc_pkg::CFG_EMPTY:     cfg_r.empty_code     <= cfg_data[cmc_pkg::CODE_W-1:0];
        cmc_pkg::CFG_HEAD:      cfg_r.head_code      <= cfg_data[cmc_pkg::CODE_W-1:0];
        cmc_pkg::CFG_GOOD_HEAD: cfg_r.good_head_code <= cfg_data[cmc_pkg::CODE_W-1:0];
        cmc_pkg::CFG_GOOD_BODY: cfg_r.good_body_code <= cfg_data[cmc_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign s2_ready = !out_valid_r || out_ready;
  assign step     = s1_valid_r && s2_ready;
  assign in_ready = !s1_valid_r || s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  cmc_classify u_classify (
    .cfg  (cfg_r),
    .code (s1_data_r.status_code),
    .cls  (cls)
  );

  cmc_stats u_stats (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cls   (cls),
    .last  (s1_data_r.last),
    .res_r (out_data)
  );

  assign out_valid = out_valid_r;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data.is_head && out_data.is_good_head))
    else $error("head and good head flagged on one beat");

  a_head_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data.is_head) |-> (out_data.head_total != '0 &&
                                           out_data.decodable_total != '0))
    else $error("head flagged but not counted");

  a_totals_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data.head_total <= out_data.decodable_total &&
                     out_data.run_starts <= out_data.decodable_total))
    else $error("sub-totals exceed decodable total");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (step && s1_data_r.last) |=> (out_valid_r && out_data.map_done))
    else $error("last beat did not close the map");

endmodule
